// ===== rtl/trial_division_factorizer_assert.svh =====
// Assertion macros for the trial division factorizer.
`ifndef TRIAL_DIVISION_FACTORIZER_ASSERT_SVH
`define TRIAL_DIVISION_FACTORIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define TDF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TDF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define TDF_ASSERT(lbl, prop, msg)
`define TDF_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/tdf_pkg.sv =====
// Shared constants and types of the trial division factorizer.
package tdf_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int FACTOR_BITS = 32;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
    localparam int STEP_BITS   = $clog2(VALUE_BITS);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [CNT_BITS-1:0]   t_count;

    // Status of the serial divider towards the sequencer
    typedef struct packed {
        logic   done;
        t_value quotient;
        t_value remainder;
    } t_div_res;

endpackage

// ===== rtl/tdf_serdiv.sv =====
// Restoring divider that produces one quotient bit per cycle.
module tdf_serdiv
    import tdf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_value   i_dividend,
    input  t_value   i_divisor,
    output t_div_res o_res
);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_step;
    t_value               r_part;
    t_value               r_quo;
    t_value               r_dsr;

    logic [VALUE_BITS:0]   w_shifted;
    logic [VALUE_BITS+1:0] w_diff;
    logic                  w_ge;
    t_value                n_part;
    t_value                n_quo;

    // Shift in the next dividend bit and try one subtract
    always_comb begin
        w_shifted = {r_part, r_quo[VALUE_BITS-1]};
        w_diff    = {1'b0, w_shifted} - {2'b00, r_dsr};
        w_ge      = !w_diff[VALUE_BITS+1];
        n_part    = w_ge ? w_diff[VALUE_BITS-1:0] : w_shifted[VALUE_BITS-1:0];
        n_quo     = {r_quo[VALUE_BITS-2:0], w_ge};
    end

    // Load operands on start, then advance one bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_part <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_part <= n_part;
                r_quo  <= n_quo;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_BITS'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_part;

endmodule

// ===== rtl/trial_division_factorizer.sv =====
// Top level of the trial division factorizer: sequencer, pending factor and output register.
//
//  channel   dir  handshake           payload
//  s_axis    in   i_s_tvalid/o_s_tready  tdata = number
//  m_axis    out  o_m_tvalid/i_m_tready  tdata = factor, tlast = last_factor,
//                                        tuser = no_factors
//
// Run time of an item grows with t, the number of factors of two, and with d, the number
// of trial divisions (one per odd divisor, plus one per repeated factor); a 32-bit
// prime takes about 32768 divisions. Each division runs on the bit-serial divider,
// one quotient bit per cycle.
// Reset clears the sequencer and the output register; no memory needs clearing.
// A factor waits in a pending register until the next one is found, so a stalled
// output only holds the sequencer when a second factor is ready.
module trial_division_factorizer
    import tdf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [31:0]            i_s_tdata,   // [31:0] number
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [FACTOR_BITS-1:0] o_m_tdata,   // [31:0] factor
    output logic                   o_m_tlast,   // last_factor
    output logic                   o_m_tuser    // [0] no_factors
);

`include "trial_division_factorizer_assert.svh"

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVEN   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_TEST   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;

    logic [2:0] r_state, n_state;
    t_value     r_rem, n_rem;
    t_value     r_d, n_d;
    logic       r_inner, n_inner;
    logic       r_div_start, n_div_start;
    t_count     r_count, n_count;
    logic       r_pend_valid, n_pend_valid;
    t_value     r_pend, n_pend;
    logic       r_pend_none, n_pend_none;
    logic                   r_out_valid, n_out_valid;
    logic [FACTOR_BITS-1:0] r_out_factor, n_out_factor;
    logic                   r_out_last, n_out_last;
    logic                   r_out_none, n_out_none;

    logic     w_out_free;
    logic     w_can_add;
    logic     w_add_go;
    t_value   w_add_val;
    t_div_res w_div;

    tdf_serdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_rem),
        .i_divisor  (r_d),
        .o_res      (w_div)
    );

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_can_add  = !r_pend_valid || w_out_free;

    // Sequence the division steps and move factors toward the output
    always_comb begin
        n_state      = r_state;
        n_rem        = r_rem;
        n_d          = r_d;
        n_inner      = r_inner;
        n_div_start  = 1'b0;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_pend_none  = r_pend_none;
        n_out_valid  = r_out_valid;
        n_out_factor = r_out_factor;
        n_out_last   = r_out_last;
        n_out_none   = r_out_none;
        w_add_go     = 1'b0;
        w_add_val    = r_d;

        // Drop the output item once taken
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_rem        = VALUE_BITS'(i_s_tdata);
                    n_count      = '0;
                    n_pend_valid = 1'b0;
                    n_pend_none  = 1'b0;
                    if (n_rem <= t_value'(1)) begin
                        n_pend       = '0;
                        n_pend_none  = 1'b1;
                        n_pend_valid = 1'b1;
                        n_state      = S_FLUSH;
                    end else begin
                        n_state = S_EVEN;
                    end
                end
            end
            S_EVEN: begin
                if (!r_rem[0]) begin
                    if (w_can_add) begin
                        w_add_go  = 1'b1;
                        w_add_val = t_value'(2);
                        n_rem     = r_rem >> 1;
                    end
                end else begin
                    n_d         = t_value'(3);
                    n_inner     = 1'b0;
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (!r_inner && (r_d > w_div.quotient)) begin
                    n_state = S_FINISH;
                end else if (w_div.remainder == '0) begin
                    if (w_can_add) begin
                        w_add_go    = 1'b1;
                        w_add_val   = r_d;
                        n_rem       = w_div.quotient;
                        n_inner     = 1'b1;
                        n_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end else begin
                    n_d         = r_d + t_value'(2);
                    n_inner     = 1'b0;
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_FINISH: begin
                if (r_rem > t_value'(1)) begin
                    if (w_can_add) begin
                        w_add_go  = 1'b1;
                        w_add_val = r_rem;
                        n_rem     = t_value'(1);
                        n_state   = S_FLUSH;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_factor = FACTOR_BITS'(r_pend);
                    n_out_last   = 1'b1;
                    n_out_none   = r_pend_none;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Push the pending factor out and hold the new one; stop at the result limit
        if (w_add_go) begin
            if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out_factor = FACTOR_BITS'(r_pend);
                n_out_last   = 1'b0;
                n_out_none   = 1'b0;
            end
            n_pend       = w_add_val;
            n_pend_valid = 1'b1;
            n_count      = r_count + 1'b1;
            if ((r_count + 1'b1) == CNT_BITS'(MAX_RESULTS)) begin
                n_div_start = 1'b0;
                n_state     = S_FLUSH;
            end
        end
    end

    // Register control state and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rem        <= '0;
            r_d          <= '0;
            r_inner      <= 1'b0;
            r_div_start  <= 1'b0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rem        <= n_rem;
            r_d          <= n_d;
            r_inner      <= n_inner;
            r_div_start  <= n_div_start;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_pend       <= n_pend;
        r_pend_none  <= n_pend_none;
        r_out_factor <= n_out_factor;
        r_out_last   <= n_out_last;
        r_out_none   <= n_out_none;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_factor;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_none;

    `TDF_ASSERT(a_none_is_last, (r_out_valid && r_out_none) |-> (r_out_last && r_out_factor == '0), "empty result must be last with zero factor")
    `TDF_ASSERT(a_count_limit, (r_count <= CNT_BITS'(MAX_RESULTS)), "result count beyond limit")
    `TDF_ASSERT(a_done_in_div, w_div.done |-> (r_state == S_DIV), "divider finished outside wait state")
    `TDF_ASSERT(a_busy_after_accept, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "ready after accepting an item")

endmodule

// ===== sim/trial_division_factorizer_tb.sv =====
// Self-checking testbench for the trial division factorizer with random stream pacing.
module trial_division_factorizer_tb;
    import tdf_pkg::*;

    // One prime factor as it should leave the block
    typedef struct packed {
        logic [FACTOR_BITS-1:0] factor;
        logic                   is_last;
        logic                   is_empty;
    } t_factor;

    // One number waiting to be offered, with the idle cycles that precede it
    typedef struct packed {
        logic [31:0] number;
        int unsigned gap;
    } t_number_job;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [FACTOR_BITS-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    t_number_job pending_numbers[$];
    t_factor     expected_factors[$];
    logic        in_taken    = 1'b0;
    int unsigned gap_count   = 0;
    int unsigned rx_cycles   = 0;
    int unsigned rx_hold     = 0;
    logic        rx_calm     = 1'b0;
    int          n_fail      = 0;

    int unsigned small_primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

    trial_division_factorizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Factor one number by trial division and queue the factors it should produce
    function automatic void predict_factors(input logic [31:0] number);
        t_value  rest;
        t_value  div;
        t_value  found[$];
        t_factor res;
        rest = t_value'(number);
        if (rest <= 1) begin
            res.factor   = '0;
            res.is_last  = 1'b1;
            res.is_empty = 1'b1;
            expected_factors = {expected_factors, res};
            return;
        end
        while (!rest[0]) begin
            found = {found, t_value'(2)};
            rest = rest >> 1;
        end
        // Bound written as a division so the square never overflows
        div = 3;
        while (div <= rest / div) begin
            while (rest % div == 0) begin
                found = {found, div};
                rest = rest / div;
            end
            div = div + 2;
        end
        if (rest > 1)
            found = {found, rest};
        // Emission stops at the result limit
        while (found.size() > MAX_RESULTS)
            void'(found.pop_back());
        foreach (found[i]) begin
            res.factor   = FACTOR_BITS'(found[i]);
            res.is_last  = (i == found.size() - 1);
            res.is_empty = 1'b0;
            expected_factors = {expected_factors, res};
        end
    endfunction

    // Idle cycles before an item: mostly none or short, a few long
    function automatic int unsigned pick_gap(input logic calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // Drive the input side at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_tvalid || in_taken)) begin
            if (pending_numbers.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (gap_count < pending_numbers[0].gap) begin
                gap_count <= gap_count + 1;
                s_tvalid  <= 1'b0;
            end else begin
                s_tdata   <= pending_numbers[0].number;
                void'(pending_numbers.pop_front());
                gap_count <= 0;
                s_tvalid  <= 1'b1;
            end
        end
    end

    // Pace the output side; hold off for a long stretch early in the run
    always @(negedge i_clk) begin
        int unsigned pick;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycles <= rx_cycles + 1;
            if (rx_cycles % 512 == 0)
                rx_calm <= ($urandom_range(0, 2) == 0);
            if (rx_cycles >= 50 && rx_cycles < 3050) begin
                m_tready <= 1'b0;
            end else if (rx_calm) begin
                m_tready <= 1'b1;
            end else if (rx_hold != 0) begin
                rx_hold  <= rx_hold - 1;
                m_tready <= 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    m_tready <= 1'b1;
                end else if (pick < 92) begin
                    rx_hold  <= $urandom_range(0, 3);
                    m_tready <= 1'b0;
                end else begin
                    rx_hold  <= $urandom_range(10, 80);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // Sample both handshakes at the rising edge: predict on input, check on output
    always @(posedge i_clk) begin
        t_factor want;
        in_taken <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready)
            predict_factors(s_tdata);
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_factors.size() == 0) begin
                n_fail = n_fail + 1;
                $display("%0t: unexpected result factor=%0d last=%0b empty=%0b",
                         $time, m_tdata, m_tlast, m_tuser);
            end else begin
                want = expected_factors.pop_front();
                if (m_tdata !== want.factor || m_tlast !== want.is_last
                        || m_tuser !== want.is_empty) begin
                    n_fail = n_fail + 1;
                    $display("%0t: expected factor=%0d last=%0b empty=%0b, got factor=%0d last=%0b empty=%0b",
                             $time, want.factor, want.is_last, want.is_empty,
                             m_tdata, m_tlast, m_tuser);
                end
            end
        end
    end

    // Build the stimulus, release reset, then drain
    initial begin
        logic [31:0] directed[$];
        t_number_job job;
        logic [63:0] acc;
        int unsigned kind;
        int unsigned p;
        logic        calm;

        // Directed: zero and one, small values, squares, extremes, longest result runs
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd8, 32'd9,
                     32'd12, 32'd25, 32'd49, 32'd97, 32'd121, 32'd360, 32'd1024,
                     32'h8000_0000, 32'hFFFF_FFFF, 32'hC000_0000, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'd3486784401, 32'd1048573, 32'd4294967291};
        foreach (directed[i]) begin
            job.number = directed[i];
            job.gap    = pick_gap(1'b0);
            pending_numbers = {pending_numbers, job};
        end

        // Random: mostly cheap values, some smooth values that reach the high bits
        calm = 1'b0;
        for (int i = 0; i < 80; i++) begin
            if (i % 20 == 0)
                calm = ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                job.number = $urandom_range(0, 1);
            end else if (kind < 50) begin
                job.number = $urandom_range(2, 4095);
            end else if (kind < 70) begin
                acc = 64'd1;
                repeat ($urandom_range(1, 40)) begin
                    p = small_primes[$urandom_range(0, 11)];
                    if (acc * p <= 64'hFFFF_FFFF)
                        acc = acc * p;
                end
                job.number = acc[31:0];
            end else if (kind < 85) begin
                job.number = (32'($urandom_range(0, 127)) * 2 + 1) << $urandom_range(0, 31);
            end else begin
                job.number = $urandom_range(4096, 262143);
            end
            job.gap = pick_gap(calm);
            pending_numbers = {pending_numbers, job};
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_numbers.size() != 0 || s_tvalid)
            @(posedge i_clk);
        while (expected_factors.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (n_fail == 0 && expected_factors.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Abort a run that hangs
    initial begin
        #32000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
